@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define CHK_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, live during reset.
`define CHK_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("%m: next-cycle check failed");

`endif

@@ sv/cocc_pkg.sv @@
`timescale 1ns / 1ps
package cocc_pkg;

  localparam int MAX_CIRCLES_DEF = 64;
  localparam int MAX_RECTS_DEF   = 64;
  localparam int COORD_BITS_DEF  = 16;

  localparam logic [2:0] KIND_CLEAR  = 3'd0;
  localparam logic [2:0] KIND_LOAD_C = 3'd1;
  localparam logic [2:0] KIND_LOAD_R = 3'd2;
  localparam logic [2:0] KIND_POINT  = 3'd3;
  localparam logic [2:0] KIND_SEG    = 3'd4;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_LOAD_C,
    OP_LOAD_R,
    OP_POINT,
    OP_SEG,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic signed [16:0] lx;
    logic signed [16:0] ly;
    logic [14:0]        sa;
    logic [14:0]        sb;
  } item_t;

endpackage

@@ sv/cocc_front.sv @@
`timescale 1ns / 1ps
module cocc_front #(
  parameter int COORD_BITS = cocc_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         kind,
  input  logic signed [15:0] x0,
  input  logic signed [15:0] y0,
  input  logic signed [15:0] x1,
  input  logic signed [15:0] y1,
  input  logic [14:0]        size_a,
  input  logic [14:0]        size_b,
  input  logic               pop,
  output cocc_pkg::item_t    item,
  output logic               item_valid
);

  localparam int CB = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int SH = 16 - CB;

  function automatic logic signed [15:0] wrap16(input logic [15:0] v);
    logic [15:0] t;
    t = v << SH;
    return $signed(t) >>> SH;
  endfunction

  cocc_pkg::item_t q [2];
  cocc_pkg::item_t nitem;
  logic            wp;
  logic            rp;
  logic [1:0]      cnt;
  logic            push;

  assign busy       = (cnt == 2'd2);
  assign push       = start && !busy;
  assign item       = q[rp];
  assign item_valid = (cnt != 2'd0);

  // classify and precompute the segment direction
  always_comb begin
    nitem.ax = wrap16(x0);
    nitem.ay = wrap16(y0);
    nitem.bx = wrap16(x1);
    nitem.by = wrap16(y1);
    nitem.sa = size_a;
    nitem.sb = size_b;
    case (kind)
      cocc_pkg::KIND_CLEAR:  nitem.op = cocc_pkg::OP_CLEAR;
      cocc_pkg::KIND_LOAD_C: nitem.op = cocc_pkg::OP_LOAD_C;
      cocc_pkg::KIND_LOAD_R: nitem.op = cocc_pkg::OP_LOAD_R;
      cocc_pkg::KIND_POINT:  nitem.op = cocc_pkg::OP_POINT;
      cocc_pkg::KIND_SEG:    nitem.op = cocc_pkg::OP_SEG;
      default:               nitem.op = cocc_pkg::OP_NONE;
    endcase
    if (nitem.op != cocc_pkg::OP_SEG) begin
      nitem.bx = nitem.ax;
      nitem.by = nitem.ay;
    end
    nitem.lx = 17'(nitem.bx) - 17'(nitem.ax);
    nitem.ly = 17'(nitem.by) - 17'(nitem.ay);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wp] <= nitem;
  end

endmodule

@@ sv/cocc_back.sv @@
`timescale 1ns / 1ps
module cocc_back #(
  parameter int MAX_CIRCLES = cocc_pkg::MAX_CIRCLES_DEF,
  parameter int MAX_RECTS   = cocc_pkg::MAX_RECTS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  cocc_pkg::item_t item,
  input  logic            item_valid,
  output logic            pop,
  output logic            done,
  output logic            status,
  output logic            hit
);

  localparam int CAW = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
  localparam int CCW = $clog2(MAX_CIRCLES + 1);
  localparam int RAW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int RCW = $clog2(MAX_RECTS + 1);
  localparam logic [CCW-1:0] C_FULL = CCW'(MAX_CIRCLES);
  localparam logic [RCW-1:0] R_FULL = RCW'(MAX_RECTS);

  typedef enum logic [2:0] {S_IDLE, S_SETUP, S_CIRC, S_RECT, S_DRAIN} state_t;

  state_t             state;
  logic [CCW-1:0]     ccount;
  logic [RCW-1:0]     rcount;
  logic [CAW-1:0]     cidx;
  logic [RAW-1:0]     ridx;
  logic               seg;
  logic               acc;
  logic signed [15:0] ax, ay, bx, by;
  logic signed [16:0] lx, ly;
  logic [33:0]        len2;
  logic signed [17:0] sx1, sy1, sx2, sy2, sdx, sdy;
  logic signed [35:0] base_x, base_y;

  // obstacle tables
  logic [46:0] cmem [MAX_CIRCLES];
  logic [61:0] rmem [MAX_RECTS];
  logic [46:0] c_rd;
  logic [61:0] r_rd;
  logic        c_we, r_we;

  assign pop  = (state == S_IDLE) && item_valid;
  assign c_we = pop && (item.op == cocc_pkg::OP_LOAD_C) && (ccount != C_FULL);
  assign r_we = pop && (item.op == cocc_pkg::OP_LOAD_R) && (rcount != R_FULL);

  always_ff @(posedge clk) begin
    if (c_we) cmem[ccount[CAW-1:0]] <= {item.ax, item.ay, item.sa};
    c_rd <= cmem[cidx];
  end

  always_ff @(posedge clk) begin
    if (r_we) rmem[rcount[RAW-1:0]] <= {item.ax, item.ay, item.sa, item.sb};
    r_rd <= rmem[ridx];
  end

  // circle pipe
  logic [7:0]         c_v;
  logic signed [15:0] c_x, c_y;
  logic signed [16:0] c1_ox, c1_oy, c1_qx, c1_qy;
  logic [14:0]        c1_r;
  logic [33:0]        c2_pox, c2_poy, c2_pqx, c2_pqy;
  logic [29:0]        c2_rr;
  logic signed [33:0] c2_a1, c2_a2, c2_c1, c2_c2;
  logic signed [34:0] c_ang;
  logic               c3_end, c3_proj;
  logic signed [34:0] c3_crs;
  logic [29:0]        c3_rr;
  logic               c4_end, c4_proj;
  logic [33:0]        c4_cm;
  logic [29:0]        c4_rr;
  logic               c5_end, c5_proj;
  logic [33:0]        c5_hh, c5_hl, c5_ll;
  logic [46:0]        c5_rlo, c5_rhi;
  logic               c6_end, c6_proj;
  logic [69:0]        c6_lhs, c6_rhs;
  logic               c7_hit;

  assign c_x   = $signed(c_rd[46:31]);
  assign c_y   = $signed(c_rd[30:15]);
  assign c_ang = 35'(c2_a1) + 35'(c2_a2);

  always_ff @(posedge clk) begin
    c1_ox   <= 17'(c_x) - 17'(ax);
    c1_oy   <= 17'(c_y) - 17'(ay);
    c1_qx   <= 17'(c_x) - 17'(bx);
    c1_qy   <= 17'(c_y) - 17'(by);
    c1_r    <= c_rd[14:0];
    c2_pox  <= 34'(c1_ox * c1_ox);
    c2_poy  <= 34'(c1_oy * c1_oy);
    c2_pqx  <= 34'(c1_qx * c1_qx);
    c2_pqy  <= 34'(c1_qy * c1_qy);
    c2_rr   <= 30'(c1_r * c1_r);
    c2_a1   <= 34'(lx * c1_ox);
    c2_a2   <= 34'(ly * c1_oy);
    c2_c1   <= 34'(lx * c1_oy);
    c2_c2   <= 34'(ly * c1_ox);
    c3_end  <= (35'(c2_pox) + 35'(c2_poy) <= 35'(c2_rr)) ||
               (35'(c2_pqx) + 35'(c2_pqy) <= 35'(c2_rr));
    c3_proj <= seg && (len2 != 34'd0) && !c_ang[34] && (c_ang <= $signed(35'(len2)));
    c3_crs  <= 35'(c2_c1) - 35'(c2_c2);
    c3_rr   <= c2_rr;
    c4_end  <= c3_end;
    c4_proj <= c3_proj;
    c4_cm   <= c3_crs[34] ? 34'(-c3_crs) : 34'(c3_crs);
    c4_rr   <= c3_rr;
    c5_end  <= c4_end;
    c5_proj <= c4_proj;
    c5_hh   <= 34'(c4_cm[33:17] * c4_cm[33:17]);
    c5_hl   <= 34'(c4_cm[33:17] * c4_cm[16:0]);
    c5_ll   <= 34'(c4_cm[16:0] * c4_cm[16:0]);
    c5_rlo  <= 47'(c4_rr * len2[16:0]);
    c5_rhi  <= 47'(c4_rr * len2[33:17]);
    c6_end  <= c5_end;
    c6_proj <= c5_proj;
    c6_lhs  <= (70'(c5_hh) << 34) + (70'(c5_hl) << 18) + 70'(c5_ll);
    c6_rhs  <= (70'(c5_rhi) << 17) + 70'(c5_rlo);
    c7_hit  <= c6_end || (c6_proj && (c6_lhs <= c6_rhs));
  end

  // rectangle pipe
  logic [5:0]         r_v;
  logic signed [18:0] rx2, ry2, rw19, rh19;
  logic signed [18:0] r1_left, r1_right, r1_bot, r1_top;
  logic signed [16:0] r1_dx, r1_dy;
  logic [14:0]        r1_w, r1_h;
  logic [16:0]        mdx, mdy;
  logic               r2_in, r3_in, r4_in;
  logic signed [17:0] e_u1 [4];
  logic signed [17:0] e_u2 [4];
  logic signed [17:0] e_d [4];
  logic signed [17:0] e_dw [4];
  logic signed [35:0] e_base [4];
  logic signed [18:0] e_cut [4];
  logic signed [18:0] e_lo [4];
  logic signed [18:0] e_hi [4];
  logic signed [19:0] r2_diff [4];
  logic               r2_rng [4];
  logic signed [18:0] r2_lo [4];
  logic signed [18:0] r2_hi [4];
  logic signed [39:0] r3_prod [4];
  logic signed [39:0] r3_lod [4];
  logic signed [39:0] r3_hid [4];
  logic               r3_rng [4];
  logic signed [39:0] r4_num [4];
  logic signed [39:0] r4_lod [4];
  logic signed [39:0] r4_hid [4];
  logic               r4_rng [4];
  logic [3:0]         e_hit;
  logic               r5_hit;

  assign rx2  = 19'($signed({r_rd[61:46], 1'b0}));
  assign ry2  = 19'($signed({r_rd[45:30], 1'b0}));
  assign rw19 = 19'($signed({1'b0, r_rd[29:15]}));
  assign rh19 = 19'($signed({1'b0, r_rd[14:0]}));
  assign mdx  = r1_dx[16] ? 17'(-r1_dx) : 17'(r1_dx);
  assign mdy  = r1_dy[16] ? 17'(-r1_dy) : 17'(r1_dy);

  always_comb begin
    for (int e = 0; e < 4; e++) begin
      if (e < 2) begin
        e_u1[e]   = sx1;
        e_u2[e]   = sx2;
        e_d[e]    = sdx;
        e_dw[e]   = sdy;
        e_base[e] = base_x;
        e_lo[e]   = r1_bot;
        e_hi[e]   = r1_top;
      end else begin
        e_u1[e]   = sy1;
        e_u2[e]   = sy2;
        e_d[e]    = sdy;
        e_dw[e]   = sdx;
        e_base[e] = base_y;
        e_lo[e]   = r1_left;
        e_hi[e]   = r1_right;
      end
    end
    e_cut[0] = r1_left;
    e_cut[1] = r1_right;
    e_cut[2] = r1_bot;
    e_cut[3] = r1_top;
    for (int e = 0; e < 4; e++) begin
      if (e_d[e] > 18'sd0) begin
        e_hit[e] = r4_rng[e] && (r4_lod[e] <= r4_num[e]) && (r4_num[e] <= r4_hid[e]);
      end else if (e_d[e] < 18'sd0) begin
        e_hit[e] = r4_rng[e] && (r4_lod[e] >= r4_num[e]) && (r4_num[e] >= r4_hid[e]);
      end else begin
        e_hit[e] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    r1_left  <= rx2 - rw19;
    r1_right <= rx2 + rw19;
    r1_bot   <= ry2 - rh19;
    r1_top   <= ry2 + rh19;
    r1_dx    <= 17'(ax) - 17'($signed(r_rd[61:46]));
    r1_dy    <= 17'(ay) - 17'($signed(r_rd[45:30]));
    r1_w     <= r_rd[29:15];
    r1_h     <= r_rd[14:0];
    r2_in    <= ({mdx, 1'b0} <= 18'(r1_w)) && ({mdy, 1'b0} <= 18'(r1_h));
    r3_in    <= r2_in;
    r4_in    <= r3_in;
    for (int e = 0; e < 4; e++) begin
      r2_diff[e] <= 20'(e_cut[e]) - 20'(e_u1[e]);
      r2_rng[e]  <= ((20'(e_u1[e]) <= 20'(e_cut[e])) && (20'(e_cut[e]) <= 20'(e_u2[e]))) ||
                    ((20'(e_u2[e]) <= 20'(e_cut[e])) && (20'(e_cut[e]) <= 20'(e_u1[e])));
      r2_lo[e]   <= e_lo[e];
      r2_hi[e]   <= e_hi[e];
      r3_prod[e] <= 40'(e_dw[e] * r2_diff[e]);
      r3_lod[e]  <= 40'(r2_lo[e] * e_d[e]);
      r3_hid[e]  <= 40'(r2_hi[e] * e_d[e]);
      r3_rng[e]  <= r2_rng[e];
      r4_num[e]  <= 40'(e_base[e]) + r3_prod[e];
      r4_lod[e]  <= r3_lod[e];
      r4_hid[e]  <= r3_hid[e];
      r4_rng[e]  <= r3_rng[e];
    end
    r5_hit <= seg ? (|e_hit) : r4_in;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ccount <= '0;
      rcount <= '0;
      cidx   <= '0;
      ridx   <= '0;
      acc    <= 1'b0;
      done   <= 1'b0;
      status <= 1'b0;
      hit    <= 1'b0;
      c_v    <= '0;
      r_v    <= '0;
    end else begin
      done   <= 1'b0;
      status <= 1'b0;
      hit    <= 1'b0;
      c_v    <= {c_v[6:0], state == S_CIRC};
      r_v    <= {r_v[4:0], state == S_RECT};
      if ((c_v[7] && c7_hit) || (r_v[5] && r5_hit)) acc <= 1'b1;
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            case (item.op)
              cocc_pkg::OP_CLEAR: begin
                ccount <= '0;
                rcount <= '0;
                done   <= 1'b1;
              end
              cocc_pkg::OP_LOAD_C: begin
                if (ccount == C_FULL) status <= 1'b1;
                else ccount <= ccount + 1'b1;
                done <= 1'b1;
              end
              cocc_pkg::OP_LOAD_R: begin
                if (rcount == R_FULL) status <= 1'b1;
                else rcount <= rcount + 1'b1;
                done <= 1'b1;
              end
              cocc_pkg::OP_POINT, cocc_pkg::OP_SEG: begin
                seg   <= (item.op == cocc_pkg::OP_SEG);
                ax    <= item.ax;
                ay    <= item.ay;
                bx    <= item.bx;
                by    <= item.by;
                lx    <= item.lx;
                ly    <= item.ly;
                acc   <= 1'b0;
                state <= S_SETUP;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_SETUP: begin
          len2   <= 34'(lx * lx) + 34'(ly * ly);
          sx1    <= $signed({ax[15], ax, 1'b0});
          sy1    <= $signed({ay[15], ay, 1'b0});
          sx2    <= $signed({bx[15], bx, 1'b0});
          sy2    <= $signed({by[15], by, 1'b0});
          sdx    <= $signed({lx, 1'b0});
          sdy    <= $signed({ly, 1'b0});
          base_x <= 36'($signed({ay[15], ay, 1'b0}) * $signed({lx, 1'b0}));
          base_y <= 36'($signed({ax[15], ax, 1'b0}) * $signed({ly, 1'b0}));
          if (ccount != '0) state <= S_CIRC;
          else if (rcount != '0) state <= S_RECT;
          else state <= S_DRAIN;
        end
        S_CIRC: begin
          if (CCW'(cidx) == ccount - 1'b1) begin
            cidx  <= '0;
            state <= (rcount != '0) ? S_RECT : S_DRAIN;
          end else begin
            cidx <= cidx + 1'b1;
          end
        end
        S_RECT: begin
          if (RCW'(ridx) == rcount - 1'b1) begin
            ridx  <= '0;
            state <= S_DRAIN;
          end else begin
            ridx <= ridx + 1'b1;
          end
        end
        S_DRAIN: begin
          if ((c_v == '0) && (r_v == '0)) begin
            done  <= 1'b1;
            hit   <= acc;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/obstacle_collision_checker_top.sv @@
`timescale 1ns / 1ps
// Circle and rectangle collision checker. An item is taken when start is high
// and busy is low; a two-entry queue sits in front of the execution engine, so
// busy rises only when two items wait. Each item gives one result, shown for a
// single cycle with done high; the receiver cannot stall it. With the engine
// idle, a clear or load item is popped from the queue and its result is
// registered on done. A query walks the circle table and then the rectangle
// table, one entry per cycle from the single read port of each table, then
// drains the compare pipelines; with both tables empty it goes straight to
// the drain. The next queued item starts at the edge that takes the result.
module obstacle_collision_checker_top #(
  parameter int MAX_CIRCLES = cocc_pkg::MAX_CIRCLES_DEF,
  parameter int MAX_RECTS   = cocc_pkg::MAX_RECTS_DEF,
  parameter int COORD_BITS  = cocc_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         kind,
  input  logic signed [15:0] x0,
  input  logic signed [15:0] y0,
  input  logic signed [15:0] x1,
  input  logic signed [15:0] y1,
  input  logic [14:0]        size_a,
  input  logic [14:0]        size_b,
  output logic               done,
  output logic               status,
  output logic               hit
);

  cocc_pkg::item_t item;
  logic            item_valid;
  logic            pop;

  cocc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .x0         (x0),
    .y0         (y0),
    .x1         (x1),
    .y1         (y1),
    .size_a     (size_a),
    .size_b     (size_b),
    .pop        (pop),
    .item       (item),
    .item_valid (item_valid)
  );

  cocc_back #(.MAX_CIRCLES(MAX_CIRCLES), .MAX_RECTS(MAX_RECTS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .pop        (pop),
    .done       (done),
    .status     (status),
    .hit        (hit)
  );

endmodule

@@ sv/cocc_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cocc_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic done,
  input logic status,
  input logic hit
);

  `CHK_NEXT(a_reset_quiet, rst, !done && !busy)
  `CHK_IMPL(a_idle_outputs, !done, !status && !hit)
  `CHK_IMPL(a_drop_no_hit, done && status, !hit)

endmodule

bind obstacle_collision_checker_top cocc_checker u_chk (.*);
